// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stream find-and-replace block.
// No dependencies; imported by every other file of the block.
package sfr_pkg;

   localparam int CHAR_W          = 8;
   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int MAX_RESULTS     = 8;
   localparam int WORD_W          = 64;
   localparam int LEN_W           = 4;
   localparam int FILL_W          = 3;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 4'd3;

   // Results caused by one input beat, lowest byte goes out first.
   typedef struct packed {
      logic [WORD_W-1:0] chars;
      logic [LEN_W-1:0]  count;
      logic              last;   // final result carries the end flag
      logic              empty;  // single result with no byte
   } burst_type;

endpackage

// ===== sv/sfr_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: request bytes, result bytes and register writes.
// Depends on sfr_pkg for widths.
interface sfr_req_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              in_end;
   modport source (output valid, in_char, in_end, input ready);
   modport sink   (input valid, in_char, in_end, output ready);
endinterface

interface sfr_rsp_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              char_valid;
   logic              out_end;
   modport source (output valid, out_char, char_valid, out_end, input ready);
   modport sink   (input valid, out_char, char_valid, out_end, output ready);
endinterface

interface sfr_csr_if import sfr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/sfr_core.sv =====
`timescale 1ns / 1ps
// Configuration registers, match window and the per-beat match decision.
// Depends on sfr_pkg and sfr_csr_if.
module sfr_core import sfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   sfr_csr_if.sink           csr,
   input  logic              accept,
   input  logic [CHAR_W-1:0] in_char,
   input  logic              in_end,
   output burst_type         burst
);

   logic [WORD_W-1:0] pattern_ff, pattern_in;
   logic [LEN_W-1:0]  pat_len_ff, pat_len_in;
   logic [WORD_W-1:0] repl_ff, repl_in;
   logic [LEN_W-1:0]  rep_len_ff, rep_len_in;
   logic [WORD_W-1:0] window_ff, window_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic [LEN_W-1:0]  plen;
   logic [LEN_W-1:0]  rlen;
   logic [FILL_W-1:0] fill_eff;
   logic [LEN_W-1:0]  n;
   logic [WORD_W-1:0] buf_w;
   logic              mismatch;
   logic              hit;
   logic              csr_write;

   assign csr.ready = 1'b1;
   assign csr_write = csr.valid && csr.ready;

   always_comb begin
      plen = pat_len_ff;
      if (pat_len_ff == '0) begin
         plen = LEN_W'(1);
      end else if (pat_len_ff > LEN_W'(MAX_PATTERN)) begin
         plen = LEN_W'(MAX_PATTERN);
      end
      rlen = rep_len_ff;
      if (rep_len_ff > LEN_W'(MAX_REPLACEMENT)) begin
         rlen = LEN_W'(MAX_REPLACEMENT);
      end
   end

   always_comb begin
      logic [LEN_W-1:0] top;
      top      = plen - LEN_W'(1);
      fill_eff = fill_ff;
      if ({1'b0, fill_ff} > top) begin
         fill_eff = top[FILL_W-1:0];
      end
      n = {1'b0, fill_eff} + LEN_W'(1);
   end

   // held bytes followed by the new byte, unused lanes zero
   always_comb begin
      buf_w    = '0;
      mismatch = 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (FILL_W'(i) < fill_eff) begin
            buf_w[i*CHAR_W +: CHAR_W] = window_ff[i*CHAR_W +: CHAR_W];
         end else if (FILL_W'(i) == fill_eff) begin
            buf_w[i*CHAR_W +: CHAR_W] = in_char;
         end
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (LEN_W'(i) < n &&
             buf_w[i*CHAR_W +: CHAR_W] != pattern_ff[i*CHAR_W +: CHAR_W]) begin
            mismatch = 1'b1;
         end
      end
      hit = (n == plen) && !mismatch;
   end

   always_comb begin
      burst     = '0;
      window_in = window_ff;
      fill_in   = fill_ff;
      priority if (hit) begin
         burst.chars = repl_ff;
         burst.count = rlen;
         burst.last  = in_end;
         if (in_end && rlen == '0) begin
            // end marker with no byte carries a zero character
            burst.chars = '0;
            burst.count = LEN_W'(1);
            burst.empty = 1'b1;
         end
         fill_in = '0;
      end else if (in_end) begin
         burst.chars = buf_w;
         burst.count = n;
         burst.last  = 1'b1;
         fill_in     = '0;
      end else if (n == plen) begin
         // oldest byte drops out of a full window
         burst.chars = buf_w;
         burst.count = LEN_W'(1);
         window_in   = buf_w >> CHAR_W;
         fill_in     = fill_eff;
      end else begin
         window_in = buf_w;
         fill_in   = n[FILL_W-1:0];
      end
      if (!accept) begin
         window_in = window_ff;
         fill_in   = fill_ff;
      end
      if (csr_write && csr.reg_index == CSR_PATTERN_LENGTH) begin
         fill_in = '0;
      end
   end

   always_comb begin
      pattern_in = pattern_ff;
      pat_len_in = pat_len_ff;
      repl_in    = repl_ff;
      rep_len_in = rep_len_ff;
      if (csr_write) begin
         if (csr.reg_index == CSR_PATTERN_BYTES)      pattern_in = csr.wdata;
         if (csr.reg_index == CSR_PATTERN_LENGTH)     pat_len_in = csr.wdata[LEN_W-1:0];
         if (csr.reg_index == CSR_REPLACEMENT_BYTES)  repl_in    = csr.wdata;
         if (csr.reg_index == CSR_REPLACEMENT_LENGTH) rep_len_in = csr.wdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         pat_len_ff <= LEN_W'(1);
         repl_ff    <= '0;
         rep_len_ff <= '0;
         window_ff  <= '0;
         fill_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         pat_len_ff <= pat_len_in;
         repl_ff    <= repl_in;
         rep_len_ff <= rep_len_in;
         window_ff  <= window_in;
         fill_ff    <= fill_in;
      end
   end

   // window never holds a whole pattern between beats
   a_fill_below_plen: assert property (@(posedge clock) disable iff (reset)
      !(csr_write && csr.reg_index == CSR_PATTERN_LENGTH) |=> ({1'b0, fill_ff} < plen))
      else $error("window fill reached pattern length");

   a_len_write_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr.reg_index == CSR_PATTERN_LENGTH) |=> (fill_ff == '0))
      else $error("pattern length write left bytes in window");

endmodule

// ===== sv/sfr_emit.sv =====
`timescale 1ns / 1ps
// Result register: holds the results of one beat and sends one per cycle while rsp is ready.
// Depends on sfr_pkg and sfr_rsp_if.
module sfr_emit import sfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      can_load,
   sfr_rsp_if.source rsp
);

   logic [WORD_W-1:0] chars_ff, chars_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              last_ff, last_in;
   logic              empty_ff, empty_in;
   logic              take;

   assign take           = rsp.valid && rsp.ready;
   assign can_load       = (count_ff == '0) || (count_ff == LEN_W'(1) && take);
   assign rsp.valid      = count_ff != '0;
   assign rsp.out_char   = chars_ff[CHAR_W-1:0];
   assign rsp.char_valid = !empty_ff;
   assign rsp.out_end    = last_ff && count_ff == LEN_W'(1);

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      priority if (load) begin
         chars_in = burst.chars;
         count_in = burst.count;
         last_in  = burst.last;
         empty_in = burst.empty;
      end else if (take) begin
         chars_in = chars_ff >> CHAR_W;
         count_in = count_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      chars_ff <= chars_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(MAX_RESULTS))
      else $error("result count out of range");

   a_load_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      load && !can_load |-> 1'b0)
      else $error("results overwritten before delivery");

endmodule

// ===== sv/stream_find_replace.sv =====
`timescale 1ns / 1ps
// Streaming replace-all of a 1..8 byte pattern by a 0..8 byte replacement.
// Latency: the first result of a beat is offered the cycle after the beat is taken.
// Throughput: one result per cycle from the result register while rsp_bus is ready; a beat
// causing k results holds input until its last is taken; others pass one per cycle if idle.
// Reset (synchronous): window empty, pattern length 1, other core registers and result count zero.
module stream_find_replace import sfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_bus,
   sfr_rsp_if.source rsp_bus,
   sfr_csr_if.sink   csr_bus
);

   burst_type burst;
   logic      accept;
   logic      can_load;

   assign req_bus.ready = can_load;
   assign accept        = req_bus.valid && req_bus.ready;

   sfr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_bus),
      .accept  (accept),
      .in_char (req_bus.in_char),
      .in_end  (req_bus.in_end),
      .burst   (burst)
   );

   sfr_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (accept && burst.count != '0),
      .burst    (burst),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

endmodule
